### rtl/gedm_pkg.sv
// Shared constants, types and helpers of the grid exit distance map.
package gedm_pkg;

    localparam int CFG_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int IDX_W = 12;
    localparam int KIND_W = 2;
    localparam int COST_W = 13;

    localparam int DEF_MAX_WIDTH = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DIM_RESET = 64;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [KIND_W-1:0] KIND_FREE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WALL = 2'd2;

    // One command word from the host side, already qualified by start.
    typedef struct packed {
        logic               load;
        logic               read;
        logic               in_range;
        logic               last;
        logic [KIND_W-1:0]  kind;
    } t_cmd;

    // A dimension of zero counts as one, and one above the maximum as the maximum.
    function automatic logic [CFG_W-1:0] eff_dim(logic [CFG_W-1:0] v, int maxv);
        if (v == '0) begin
            return CFG_W'(1);
        end
        if (int'(v) > maxv) begin
            return CFG_W'(maxv);
        end
        return v;
    endfunction

endpackage

### rtl/gedm_relax.sv
// Shared relaxation unit: best cost of a cell from two neighbors.
module gedm_relax #(
    parameter int NW = 13
) (
    input  logic [NW:0]   i_cen,
    input  logic [NW:0]   i_na,
    input  logic          i_a_ok,
    input  logic [NW:0]   i_nb,
    input  logic          i_b_ok,
    output logic [NW-1:0] o_cost,
    output logic          o_upd
);

    logic          a_use;
    logic          b_use;
    logic [NW:0]   a_inc;
    logic [NW:0]   b_inc;
    logic [NW:0]   best;

    // Bit NW of each word is the wall mark; walls neither take nor pass distance.
    assign a_use = i_a_ok && !i_na[NW] && !i_cen[NW];
    assign b_use = i_b_ok && !i_nb[NW] && !i_cen[NW];
    assign a_inc = {1'b0, i_na[NW-1:0]} + (NW+1)'(1);
    assign b_inc = {1'b0, i_nb[NW-1:0]} + (NW+1)'(1);

    always_comb begin
        best = {1'b0, i_cen[NW-1:0]};
        if (a_use && (a_inc < best)) begin
            best = a_inc;
        end
        if (b_use && (b_inc < best)) begin
            best = b_inc;
        end
    end

    assign o_cost = best[NW-1:0];
    assign o_upd  = best < {1'b0, i_cen[NW-1:0]};

endmodule

### rtl/gedm_core.sv
// Cell store and sweep sequencer of the grid exit distance map.
module gedm_core #(
    parameter int MAX_WIDTH = gedm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gedm_pkg::DEF_MAX_HEIGHT,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW = $clog2(DEPTH),
    localparam int DIM_MAX = (1 << gedm_pkg::CFG_W) - 1,
    localparam int EW = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX,
    localparam int EH = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX,
    localparam int NW = $clog2(EW * EH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gedm_pkg::t_cmd             i_cmd,
    input  logic [AW-1:0]              i_idx,
    input  logic [gedm_pkg::CFG_W-1:0] i_w,
    input  logic [gedm_pkg::CFG_W-1:0] i_h,
    input  logic [NW-1:0]              i_n,
    output logic                       o_busy,
    output logic                       o_res_valid,
    output logic [NW-1:0]              o_res_cost,
    output logic                       o_res_wall
);

    localparam int CMPW = (AW > NW) ? AW : NW;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CLEAR   = 9'b000000010,
        S_APPLY   = 9'b000000100,
        S_INIT_RD = 9'b000001000,
        S_INIT_WR = 9'b000010000,
        S_RD_C    = 9'b000100000,
        S_RD_A    = 9'b001000000,
        S_RD_B    = 9'b010000000,
        S_WR      = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic r_job, n_job;
    logic [AW-1:0] r_c, n_c;
    logic [gedm_pkg::CFG_W-1:0] r_x, n_x;
    logic [gedm_pkg::CFG_W-1:0] r_y, n_y;
    logic r_bwd, n_bwd;
    logic r_chg, n_chg;

    logic [AW-1:0] r_pidx;
    logic [gedm_pkg::KIND_W-1:0] r_pkind;
    logic r_plast;
    logic r_pok;

    logic [NW:0] r_cen;
    logic [NW:0] r_na;
    logic [NW:0] r_rdata;
    logic r_res_pend;
    logic r_res_ok;

    logic [NW:0] mem [DEPTH];

    logic we;
    logic [AW-1:0] waddr;
    logic [NW:0] wdata;
    logic [AW-1:0] raddr;

    logic [CMPW-1:0] n_m1;
    logic c_last;
    logic [gedm_pkg::CFG_W-1:0] w_m1;
    logic [gedm_pkg::CFG_W-1:0] h_m1;
    logic a_ok;
    logic b_ok;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [NW-1:0] relax_cost;
    logic relax_upd;

    function automatic logic [NW:0] load_word(logic [gedm_pkg::KIND_W-1:0] k,
                                              logic [NW-1:0] n);
        if (k >= gedm_pkg::KIND_WALL) begin
            return {1'b1, {NW{1'b0}}};
        end
        if (k == gedm_pkg::KIND_EXIT) begin
            return {1'b0, {NW{1'b0}}};
        end
        return {1'b0, n};
    endfunction

    assign n_m1   = CMPW'(i_n) - CMPW'(1);
    assign c_last = CMPW'(r_c) == n_m1;
    assign w_m1   = i_w - gedm_pkg::CFG_W'(1);
    assign h_m1   = i_h - gedm_pkg::CFG_W'(1);

    // Forward sweeps look left and up, backward sweeps right and down.
    assign a_ok   = r_bwd ? (r_x != w_m1) : (r_x != '0);
    assign b_ok   = r_bwd ? (r_y != h_m1) : (r_y != '0);
    assign addr_a = !a_ok ? r_c : (r_bwd ? r_c + AW'(1) : r_c - AW'(1));
    assign addr_b = !b_ok ? r_c : (r_bwd ? r_c + AW'(i_w) : r_c - AW'(i_w));

    gedm_relax #(
        .NW(NW)
    ) u_relax (
        .i_cen (r_cen),
        .i_na  (r_na),
        .i_a_ok(a_ok),
        .i_nb  (r_rdata),
        .i_b_ok(b_ok),
        .o_cost(relax_cost),
        .o_upd (relax_upd)
    );

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_c     = r_c;
        n_x     = r_x;
        n_y     = r_y;
        n_bwd   = r_bwd;
        n_chg   = r_chg;
        we      = 1'b0;
        waddr   = r_c;
        wdata   = {1'b0, i_n};
        raddr   = r_c;
        unique case (r_state)
            S_IDLE: begin
                raddr = i_idx;
                if (i_cmd.load) begin
                    if (r_job) begin
                        we    = i_cmd.in_range;
                        waddr = i_idx;
                        wdata = load_word(i_cmd.kind, i_n);
                        if (i_cmd.last) begin
                            n_job   = 1'b0;
                            n_c     = '0;
                            n_state = S_INIT_RD;
                        end
                    end else begin
                        // A new job first rebuilds the whole grid as free cells.
                        n_c     = '0;
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                we = 1'b1;
                if (c_last) begin
                    n_state = S_APPLY;
                end else begin
                    n_c = r_c + AW'(1);
                end
            end
            S_APPLY: begin
                we    = r_pok;
                waddr = r_pidx;
                wdata = load_word(r_pkind, i_n);
                n_job = 1'b1;
                if (r_plast) begin
                    n_job   = 1'b0;
                    n_c     = '0;
                    n_state = S_INIT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INIT_RD: begin
                n_state = S_INIT_WR;
            end
            S_INIT_WR: begin
                we = !r_rdata[NW] && (r_rdata[NW-1:0] != '0);
                if (c_last) begin
                    n_c     = '0;
                    n_x     = '0;
                    n_y     = '0;
                    n_bwd   = 1'b0;
                    n_chg   = 1'b0;
                    n_state = S_RD_C;
                end else begin
                    n_c     = r_c + AW'(1);
                    n_state = S_INIT_RD;
                end
            end
            S_RD_C: begin
                n_state = S_RD_A;
            end
            S_RD_A: begin
                raddr   = addr_a;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                raddr   = addr_b;
                n_state = S_WR;
            end
            S_WR: begin
                we      = relax_upd;
                wdata   = {1'b0, relax_cost};
                n_state = S_RD_C;
                if (relax_upd) begin
                    n_chg = 1'b1;
                end
                if (!r_bwd) begin
                    if (c_last) begin
                        n_bwd = 1'b1;
                        n_c   = AW'(n_m1);
                        n_x   = w_m1;
                        n_y   = h_m1;
                    end else begin
                        n_c = r_c + AW'(1);
                        if (r_x == w_m1) begin
                            n_x = '0;
                            n_y = r_y + gedm_pkg::CFG_W'(1);
                        end else begin
                            n_x = r_x + gedm_pkg::CFG_W'(1);
                        end
                    end
                end else begin
                    if (r_c == '0) begin
                        // A full round with no improvement ends the job.
                        if (r_chg || relax_upd) begin
                            n_bwd = 1'b0;
                            n_chg = 1'b0;
                            n_c   = '0;
                            n_x   = '0;
                            n_y   = '0;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_c = r_c - AW'(1);
                        if (r_x == '0) begin
                            n_x = w_m1;
                            n_y = r_y - gedm_pkg::CFG_W'(1);
                        end else begin
                            n_x = r_x - gedm_pkg::CFG_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_job      <= 1'b0;
            r_c        <= '0;
            r_x        <= '0;
            r_y        <= '0;
            r_bwd      <= 1'b0;
            r_chg      <= 1'b0;
            r_res_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_job      <= n_job;
            r_c        <= n_c;
            r_x        <= n_x;
            r_y        <= n_y;
            r_bwd      <= n_bwd;
            r_chg      <= n_chg;
            r_res_pend <= (r_state == S_IDLE) && i_cmd.read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_cmd.load && !r_job) begin
            r_pidx  <= i_idx;
            r_pkind <= i_cmd.kind;
            r_plast <= i_cmd.last;
            r_pok   <= i_cmd.in_range;
        end
        if ((r_state == S_IDLE) && i_cmd.read) begin
            r_res_ok <= i_cmd.in_range;
        end
        if (r_state == S_RD_A) begin
            r_cen <= r_rdata;
        end
        if (r_state == S_RD_B) begin
            r_na <= r_rdata;
        end
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_res_valid = r_res_pend;
    assign o_res_wall  = r_res_ok && r_rdata[NW];
    assign o_res_cost  = (r_res_ok && !r_rdata[NW]) ? r_rdata[NW-1:0] : '0;

endmodule

### rtl/grid_exit_distance_map_unit.sv
// Top level of the grid exit distance map: configuration, command decode and results.
//
// A word is taken on start while busy is low. Loads go one per cycle and give no
// result; a read gives its result with o_valid in the cycle after it is taken,
// and reads also stream one per cycle. The result cannot be held off, so it must be
// taken in that cycle. The first load of a job clears the width*height cells of the
// grid before it lands. The load marked last starts the computation: a setup pass
// over the cells, then rounds of a forward and a backward sweep, each cell read as
// itself and its two neighbors and then written, repeated until a round changes nothing.
// The cell memory has a single read port, which the shared relaxation unit
// visits one neighbor a cycle; busy stays high throughout.
module grid_exit_distance_map_unit #(
    parameter int MAX_WIDTH = gedm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gedm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [gedm_pkg::IDX_W-1:0]      i_cell_index,
    input  logic [gedm_pkg::KIND_W-1:0]     i_cell_kind,
    input  logic                            i_last_cell,
    output logic                            o_valid,
    output logic [gedm_pkg::COST_W-1:0]     o_cost,
    output logic                            o_is_wall,
    input  logic                            i_cfg_we,
    input  logic [gedm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gedm_pkg::CFG_W-1:0]      i_cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(DEPTH);
    localparam int DIM_MAX = (1 << gedm_pkg::CFG_W) - 1;
    localparam int EW = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int EH = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam int NW = $clog2(EW * EH + 1);
    localparam int PW = 2 * gedm_pkg::CFG_W;
    localparam int IX = (gedm_pkg::IDX_W > NW) ? gedm_pkg::IDX_W : NW;
    localparam int IW = (AW > gedm_pkg::IDX_W) ? AW : gedm_pkg::IDX_W;
    localparam logic [gedm_pkg::CFG_W-1:0] W_RESET =
        gedm_pkg::eff_dim(gedm_pkg::CFG_W'(gedm_pkg::DIM_RESET), MAX_WIDTH);
    localparam logic [gedm_pkg::CFG_W-1:0] H_RESET =
        gedm_pkg::eff_dim(gedm_pkg::CFG_W'(gedm_pkg::DIM_RESET), MAX_HEIGHT);

    logic [gedm_pkg::CFG_W-1:0] r_w;
    logic [gedm_pkg::CFG_W-1:0] r_h;
    logic [NW-1:0] r_n;

    logic [gedm_pkg::CFG_W-1:0] w_new;
    logic [gedm_pkg::CFG_W-1:0] h_new;
    logic [PW-1:0] n_by_w;
    logic [PW-1:0] n_by_h;
    logic [IW-1:0] idx_ext;
    gedm_pkg::t_cmd cmd;
    logic [NW-1:0] res_cost;

    // Dimensions are kept already clamped, with the cell count alongside.
    assign w_new  = gedm_pkg::eff_dim(i_cfg_wdata, MAX_WIDTH);
    assign h_new  = gedm_pkg::eff_dim(i_cfg_wdata, MAX_HEIGHT);
    assign n_by_w = PW'(w_new) * PW'(r_h);
    assign n_by_h = PW'(r_w) * PW'(h_new);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= W_RESET;
            r_h <= H_RESET;
            r_n <= NW'(PW'(W_RESET) * PW'(H_RESET));
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gedm_pkg::REG_GRID_WIDTH: begin
                    r_w <= w_new;
                    r_n <= NW'(n_by_w);
                end
                gedm_pkg::REG_GRID_HEIGHT: begin
                    r_h <= h_new;
                    r_n <= NW'(n_by_h);
                end
                default: begin
                    r_w <= r_w;
                end
            endcase
        end
    end

    assign idx_ext      = IW'(i_cell_index);
    assign cmd.load     = start && !i_mode;
    assign cmd.read     = start && i_mode;
    assign cmd.in_range = IX'(i_cell_index) < IX'(r_n);
    assign cmd.last     = i_last_cell;
    assign cmd.kind     = i_cell_kind;

    gedm_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_idx      (idx_ext[AW-1:0]),
        .i_w        (r_w),
        .i_h        (r_h),
        .i_n        (r_n),
        .o_busy     (busy),
        .o_res_valid(o_valid),
        .o_res_cost (res_cost),
        .o_res_wall (o_is_wall)
    );

    assign o_cost = gedm_pkg::COST_W'(res_cost);

endmodule
